[src/ksta_pkg.sv]
// Shared types and constants of the keyed slot table with aging.
// Holds grid geometry, request and status codes, and the slot entry format.
// No dependencies.
`default_nettype none

package ksta_pkg;

  localparam int ROWS   = 3;
  localparam int COLS   = 3;
  localparam int NSLOTS = ROWS * COLS;

  localparam int IW  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;   // slot index
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;       // row counter
  localparam int CLW = (COLS > 1) ? $clog2(COLS) : 1;       // column counter
  localparam int CW  = $clog2(NSLOTS + 1);                  // fill count

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_TAKE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_SCAN  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_BAD_LIFE  = 3'd2,
    ST_DUP       = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_NONE_EXP  = 3'd6
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] key;
    logic [15:0] lifetime;
    logic [11:0] now;
  } req_t;

  typedef struct packed {
    logic [15:0] key;
    logic [11:0] entry_time;
    logic [15:0] lifetime;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef struct packed {
    status_e            status;
    logic [4:0]         slot_row;
    logic [4:0]         slot_col;
    logic [15:0]        found_key;
    logic signed [17:0] remaining;
  } res_t;

endpackage

`default_nettype wire

[src/keyed_slot_table_with_aging.sv]
// Top level of the keyed slot table with aging: stream ports and result register.
// Depends on ksta_pkg and ksta_engine.
// Flow: a rejected request (bad key or lifetime) skips the memory walk; a
// searched request walks the slot memory with one read per cycle until a hit
// or the last slot. The result is held in the engine's result register and
// then in the output register.
// One request at a time: the next is taken once the result has moved into the
// output register. Reset clears the used marks and count at once.
`default_nettype none

module keyed_slot_table_with_aging (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // key[15:0], lifetime[31:16], now[43:32], zero
  input  wire logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // slot_row[4:0], slot_col[9:5],
                                            // found_key[25:10], remaining[43:26], zero
  output logic [2:0]       m_axis_tuser_o   // status[2:0]
);
  import ksta_pkg::*;

  req_t req;
  res_t res;
  logic res_valid, res_ready;

  logic tvalid_q;
  res_t out_q;

  // Unpack one request transaction.
  assign req.kind     = kind_e'(s_axis_tuser_i);
  assign req.key      = s_axis_tdata_i[15:0];
  assign req.lifetime = s_axis_tdata_i[31:16];
  assign req.now      = s_axis_tdata_i[43:32];

  ksta_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load a result when empty or being drained this cycle.
  assign res_ready = !tvalid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (res_ready) begin
      tvalid_q <= res_valid;
    end
  end

  // Hold the payload while the transaction waits.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {4'b0000, out_q.remaining, out_q.found_key,
                            out_q.slot_col, out_q.slot_row};

endmodule

`default_nettype wire

[src/ksta_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
`default_nettype none

module ksta_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/ksta_engine.sv]
// Request sequencer: walks the slot memory, decides each request, writes back.
// Holds used marks and fill count in flops. Depends on ksta_pkg, ksta_ram.
`default_nettype none

module ksta_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire ksta_pkg::req_t req_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output ksta_pkg::res_t      res_o
);
  import ksta_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  res_t            res_q, res_d;
  logic [NSLOTS-1:0] used_q, used_d;
  logic [CW-1:0]   count_q, count_d;

  logic [IW-1:0]   idx_q, idx_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CLW-1:0]  col_q, col_d;
  logic            issuing_q, issuing_d;

  logic            chk_vld_q, chk_vld_d;
  logic            chk_last_q, chk_last_d;
  logic [IW-1:0]   chk_idx_q, chk_idx_d;
  logic [RW-1:0]   chk_row_q, chk_row_d;
  logic [CLW-1:0]  chk_col_q, chk_col_d;

  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [EW-1:0]   ram_rdata;
  entry_t          rd;

  logic            last_slot;
  logic            chk_used, key_match, expired, hit;
  logic [16:0]     deadline;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic [RW-1:0]   free_row;
  logic [CLW-1:0]  free_col;

  ksta_ram #(
    .Width (EW),
    .Depth (NSLOTS),
    .AddrW (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // Compare stage: entry read last cycle against the held request.
  assign chk_used  = used_q[chk_idx_q];
  assign key_match = chk_used && (rd.key == req_q.key);
  assign deadline  = 17'(rd.lifetime) + 17'(rd.entry_time);
  assign expired   = chk_used && (17'(req_q.now) > deadline);
  assign hit       = chk_vld_q && ((req_q.kind == KIND_SCAN) ? expired : key_match);
  assign last_slot = (idx_q == IW'(NSLOTS - 1));

  // First free slot, row-major.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    free_row   = '0;
    free_col   = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (!used_q[r*COLS + c] && !free_found) begin
          free_found = 1'b1;
          free_idx   = IW'(r*COLS + c);
          free_row   = RW'(r);
          free_col   = CLW'(c);
        end
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    used_d     = used_q;
    count_d    = count_q;
    idx_d      = idx_q;
    row_d      = row_q;
    col_d      = col_q;
    issuing_d  = issuing_q;
    chk_vld_d  = 1'b0;
    chk_last_d = 1'b0;
    chk_idx_d  = idx_q;
    chk_row_d  = row_q;
    chk_col_d  = col_q;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = '{key: req_q.key, entry_time: req_q.now, lifetime: req_q.lifetime};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d  = req_i;
          res_d  = '0;
          idx_d  = '0;
          row_d  = '0;
          col_d  = '0;
          if (req_i.kind != KIND_SCAN && req_i.key == 16'd0) begin
            res_d.status = ST_BAD_KEY;
            state_d      = S_DONE;
          end else if (req_i.kind == KIND_PUT && req_i.lifetime == 16'd0) begin
            res_d.status = ST_BAD_LIFE;
            state_d      = S_DONE;
          end else begin
            issuing_d = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; advance row and column with the index.
        ram_re     = issuing_q;
        chk_vld_d  = issuing_q;
        chk_last_d = issuing_q && last_slot;
        if (issuing_q) begin
          if (last_slot) begin
            issuing_d = 1'b0;
          end else begin
            idx_d = idx_q + IW'(1);
            if (col_q == CLW'(COLS - 1)) begin
              col_d = '0;
              row_d = row_q + RW'(1);
            end else begin
              col_d = col_q + CLW'(1);
            end
          end
        end

        if (hit) begin
          issuing_d = 1'b0;
          chk_vld_d = 1'b0;
          state_d   = S_DONE;
          res_d     = '0;
          if (req_q.kind == KIND_PUT) begin
            res_d.status = ST_DUP;
          end else begin
            res_d.status   = ST_OK;
            res_d.slot_row = 5'(chk_row_q) + 5'd1;
            res_d.slot_col = 5'(chk_col_q) + 5'd1;
            case (req_q.kind)
              KIND_TAKE: begin
                used_d[chk_idx_q] = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - CW'(1);
                end
              end
              KIND_QUERY: begin
                res_d.remaining = signed'(18'(deadline) - 18'(req_q.now));
              end
              default: begin
                res_d.found_key = rd.key;
              end
            endcase
          end
        end else if (chk_vld_q && chk_last_q) begin
          state_d = S_DONE;
          res_d   = '0;
          case (req_q.kind)
            KIND_PUT: begin
              if (free_found && (count_q < CW'(NSLOTS))) begin
                ram_we            = 1'b1;
                used_d[free_idx]  = 1'b1;
                count_d           = count_q + CW'(1);
                res_d.status      = ST_OK;
                res_d.slot_row    = 5'(free_row) + 5'd1;
                res_d.slot_col    = 5'(free_col) + 5'd1;
              end else begin
                res_d.status = ST_FULL;
              end
            end
            KIND_SCAN: res_d.status = ST_NONE_EXP;
            default:   res_d.status = ST_NOT_FOUND;
          endcase
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      count_q    <= '0;
      issuing_q  <= 1'b0;
      chk_vld_q  <= 1'b0;
      chk_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      count_q    <= count_d;
      issuing_q  <= issuing_d;
      chk_vld_q  <= chk_vld_d;
      chk_last_q <= chk_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    idx_q     <= idx_d;
    row_q     <= row_d;
    col_q     <= col_d;
    chk_idx_q <= chk_idx_d;
    chk_row_q <= chk_row_d;
    chk_col_q <= chk_col_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  a_count_matches_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(count_q))
    else $error("fill count differs from number of used marks");

  a_write_to_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !used_q[ram_waddr])
    else $error("slot write targets a used slot");

  a_no_read_outside_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (state_q == S_SCAN))
    else $error("memory read issued outside a scan");

  a_ok_has_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OK) |-> (res_o.slot_row != 5'd0))
    else $error("successful result without a slot");

endmodule

`default_nettype wire
